// ===== rtl/bdll_pkg.sv =====
// bdll_pkg: shared types and constants for the bounded doubly linked list
// no dependencies; imported by every rtl module of the block
package bdll_pkg;

    localparam int NODES = 64;
    localparam int IW = $clog2(NODES);
    localparam int LW = $clog2(NODES + 1);
    localparam int QDEPTH = 2;

    localparam logic [LW-1:0] NIL = LW'(NODES);

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_KEY   = 3'd2,
        OP_REM_FRONT = 3'd3,
        OP_REM_BACK  = 3'd4,
        OP_REM_VAL   = 3'd5,
        OP_NOP6      = 3'd6,
        OP_NOP7      = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
        logic signed [31:0] key;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] occupancy;
    } t_out;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
        logic signed [31:0] target;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DECIDE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_RD_PREV,
        S_RD_NEXT,
        S_LINK,
        S_DONE
    } t_state;

endpackage

// ===== rtl/bdll_front.sv =====
// bdll_front: accepts command transactions and classifies them into engine commands
// depends on bdll_pkg; feeds the command queue in bdll_queue
module bdll_front import bdll_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_item,
    input  logic i_q_full,
    output logic o_busy,
    output logic o_push,
    output t_cmd o_cmd
);

    logic r_pend;

    assign o_busy = r_pend | i_q_full;
    assign o_push = i_start & ~o_busy;

    always_comb begin
        o_cmd.op     = t_op'(i_item.opcode);
        o_cmd.value  = i_item.value;
        o_cmd.target = (i_item.opcode == OP_INS_KEY) ? i_item.key : i_item.value;
    end

    // one transaction in flight: sequential service
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (o_push) begin
            r_pend <= 1'b1;
        end else if (i_q_full == 1'b0 && r_pend) begin
            r_pend <= 1'b0;
        end
    end

endmodule

// ===== rtl/bdll_queue.sv =====
// bdll_queue: short command queue between front and engine
// depends on bdll_pkg
module bdll_queue import bdll_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PW = $clog2(QDEPTH);

    t_cmd             r_mem [QDEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [PW:0]      r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push && !o_full) - (PW+1)'(i_pop && o_valid);
        end
    end

endmodule

// ===== rtl/bdll_engine.sv =====
// bdll_engine: list engine with node store, free list, search walk and relink
// depends on bdll_pkg; consumes commands from bdll_queue
module bdll_engine import bdll_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_idle,
    output logic o_strobe,
    output t_out o_result
);

    logic signed [31:0] r_val_mem  [NODES];
    logic [LW-1:0]      r_next_mem [NODES];
    logic [LW-1:0]      r_prev_mem [NODES];

    t_state r_state, n_state;
    logic [IW-1:0] r_clr;
    logic [LW-1:0] r_front, r_back, r_free, r_cnt;
    t_cmd          r_cmd;
    logic [LW-1:0] r_q, r_n, r_p, r_s, r_cur;
    logic [LW-1:0] r_steps;
    logic signed [31:0] r_rd_val;
    logic [LW-1:0] r_rd_next, r_rd_prev;
    logic [1:0]    r_st;
    logic          r_strobe;

    logic [IW-1:0] rd_addr;
    logic          full, empty;
    logic          srch_hit, srch_last;

    assign full  = (r_free == NIL);
    assign empty = (r_front == NIL) || (r_back == NIL);
    assign srch_hit  = (r_rd_val == r_cmd.target);
    assign srch_last = (r_rd_next == NIL) || (r_steps == LW'(NODES - 1));

    // single read port per array, registered
    always_ff @(posedge i_clk) begin
        r_rd_val  <= r_val_mem[rd_addr];
        r_rd_next <= r_next_mem[rd_addr];
        r_rd_prev <= r_prev_mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (r_clr == IW'(NODES - 1)) n_state = S_IDLE;
            S_IDLE:    if (i_valid) n_state = S_DECIDE;
            S_DECIDE: begin
                unique case (r_cmd.op)
                    OP_INS_FRONT, OP_INS_BACK: n_state = full ? S_DONE : S_RD_PREV;
                    OP_INS_KEY: n_state = (full || r_front == NIL) ? S_DONE : S_SRCH_RD;
                    OP_REM_FRONT, OP_REM_BACK: n_state = empty ? S_DONE : S_RD_PREV;
                    OP_REM_VAL: n_state = empty ? S_DONE : S_SRCH_RD;
                    default:    n_state = S_DONE;
                endcase
            end
            S_SRCH_RD: n_state = S_SRCH_CMP;
            S_SRCH_CMP: begin
                if (srch_hit) n_state = S_RD_PREV;
                else if (srch_last) n_state = S_DONE;
                else n_state = S_SRCH_RD;
            end
            S_RD_PREV: n_state = S_RD_NEXT;
            S_RD_NEXT: n_state = S_LINK;
            S_LINK:    n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_state == S_IDLE) && i_valid;
        o_idle = (r_state == S_IDLE) && !i_valid;
        unique case (r_state)
            S_SRCH_RD: rd_addr = r_cur[IW-1:0];
            S_RD_NEXT: rd_addr = r_n[IW-1:0];
            default:   rd_addr = r_q[IW-1:0];
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result.status    = r_st;
    assign o_result.occupancy = 7'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_front  <= NIL;
            r_back   <= NIL;
            r_free   <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == S_DONE);
            r_state  <= n_state;
            unique case (r_state)
                S_CLEAR: begin
                    r_next_mem[r_clr] <= LW'(r_clr) + 1'b1;
                    r_clr <= r_clr + 1'b1;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                    end
                end
                S_DECIDE: begin
                    r_n     <= r_free;
                    r_cur   <= r_front;
                    r_steps <= '0;
                    unique case (r_cmd.op)
                        OP_INS_FRONT, OP_INS_BACK, OP_INS_KEY: begin
                            if (full) r_st <= ST_FULL;
                            else if (r_cmd.op == OP_INS_KEY && r_front == NIL)
                                r_st <= ST_NOTFOUND;
                            else r_st <= ST_DONE;
                            r_q <= (r_cmd.op == OP_INS_FRONT) ? r_front : NIL;
                        end
                        OP_REM_FRONT, OP_REM_BACK, OP_REM_VAL: begin
                            r_st <= empty ? ST_EMPTY : ST_DONE;
                            r_q  <= (r_cmd.op == OP_REM_FRONT) ? r_front : r_back;
                        end
                        default: r_st <= ST_DONE;
                    endcase
                end
                S_SRCH_CMP: begin
                    if (srch_hit) begin
                        r_q <= r_cur;
                    end else if (srch_last) begin
                        r_st <= ST_NOTFOUND;
                    end else begin
                        r_cur   <= r_rd_next;
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_RD_NEXT: begin
                    r_p <= r_rd_prev;
                    r_s <= r_rd_next;
                end
                S_LINK: begin
                    if (r_cmd.op == OP_INS_FRONT || r_cmd.op == OP_INS_BACK ||
                        r_cmd.op == OP_INS_KEY) begin
                        r_val_mem[r_n[IW-1:0]] <= r_cmd.value;
                        r_free <= r_rd_next;
                        r_cnt  <= r_cnt + 1'b1;
                        if (r_cmd.op == OP_INS_BACK || empty) begin
                            r_prev_mem[r_n[IW-1:0]] <= r_back;
                            r_next_mem[r_n[IW-1:0]] <= NIL;
                            if (empty) r_front <= r_n;
                            else r_next_mem[r_back[IW-1:0]] <= r_n;
                            r_back <= r_n;
                        end else begin
                            r_prev_mem[r_n[IW-1:0]] <= r_p;
                            r_next_mem[r_n[IW-1:0]] <= r_q;
                            r_prev_mem[r_q[IW-1:0]] <= r_n;
                            if (r_p != NIL) r_next_mem[r_p[IW-1:0]] <= r_n;
                            else r_front <= r_n;
                        end
                    end else begin
                        if (r_p != NIL) r_next_mem[r_p[IW-1:0]] <= r_s;
                        else r_front <= r_s;
                        if (r_s != NIL) r_prev_mem[r_s[IW-1:0]] <= r_p;
                        else r_back <= r_p;
                        r_next_mem[r_q[IW-1:0]] <= r_free;
                        r_free <= r_q;
                        r_cnt  <= r_cnt - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    property p_count_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt <= LW'(NODES);
    endproperty
    assert property (p_count_range) else $error("entry count out of range");

    property p_empty_count;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_IDLE && r_front == NIL) |-> (r_cnt == '0);
    endproperty
    assert property (p_empty_count) else $error("empty list with nonzero count");

    property p_full_free;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_IDLE && r_cnt == LW'(NODES)) |-> (r_free == NIL);
    endproperty
    assert property (p_full_free) else $error("full count with free node");

endmodule

// ===== rtl/bounded_doubly_linked_list.sv =====
// bounded_doubly_linked_list: top level, front classifier, command queue, list engine
// depends on bdll_pkg, bdll_front, bdll_queue, bdll_engine
//
// usage: drive i_item and raise start; the transaction is taken on an edge
// where busy is low. one result per transaction appears on o_result for
// exactly one cycle with o_done high; the receiver cannot stall it.
// a transaction that only returns a status (store full, list empty, insert
// before key into an empty list, unused opcode) goes straight to S_DONE.
// front and back inserts and removes read in S_RD_PREV and S_RD_NEXT, then
// relink in S_LINK. searches (insert before key, remove value) walk from the
// front with a read and a compare state per entry visited, bound by the
// single registered read port of the node store; a miss ends at the tail.
// one transaction at a time: busy stays high until the result has been
// reported and the engine is idle again.
// reset: i_rst_n low synchronously clears control state, then a clearing
// pass over all NODES entries chains the free list; busy stays high meanwhile.
module bounded_doubly_linked_list import bdll_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_done,
    output t_out o_result
);

    logic q_full, push, pop, q_valid, e_idle, f_busy;
    t_cmd f_cmd, q_cmd;
    logic r_wait;

    bdll_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_item(i_item),
        .i_q_full(q_full | r_wait), .o_busy(f_busy), .o_push(push), .o_cmd(f_cmd)
    );

    bdll_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_cmd(f_cmd),
        .i_pop(pop), .o_full(q_full), .o_valid(q_valid), .o_cmd(q_cmd)
    );

    bdll_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_cmd(q_cmd),
        .o_pop(pop), .o_idle(e_idle), .o_strobe(o_done), .o_result(o_result)
    );

    // hold off new work until the current transaction has reported
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait <= 1'b1;
        end else if (push) begin
            r_wait <= 1'b1;
        end else if (e_idle && !q_valid && !o_done) begin
            r_wait <= 1'b0;
        end
    end

    assign busy = f_busy | r_wait;

endmodule

// ===== test/bounded_doubly_linked_list_test.sv =====
// bounded_doubly_linked_list_test: self-checking bench for the bounded doubly linked list
// depends on bdll_pkg and the bounded_doubly_linked_list rtl; keeps its own list model
module bounded_doubly_linked_list_test;
    import bdll_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_in  i_item = '0;
    logic busy;
    logic o_done;
    t_out o_result;

    bounded_doubly_linked_list u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .i_item(i_item),
        .busy(busy),
        .o_done(o_done),
        .o_result(o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // list model kept as an ordered queue of values, front first
    logic signed [31:0] list_vals[$];
    t_out expected_results[$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int cycles = 0;
    int burst_left = 0;
    int op_seen[8];
    int status_seen[4];

    function automatic t_out predict_list_op(t_in it);
        t_out r;
        t_status st;
        int idx;
        bit full;
        bit empty;
        st = ST_DONE;
        full = (list_vals.size() >= NODES);
        empty = (list_vals.size() == 0);
        idx = -1;
        case (t_op'(it.opcode))
            OP_INS_FRONT: begin
                if (full) st = ST_FULL;
                else list_vals.push_front(it.value);
            end
            OP_INS_BACK: begin
                if (full) st = ST_FULL;
                else list_vals.push_back(it.value);
            end
            OP_INS_KEY: begin
                if (full) st = ST_FULL;
                else begin
                    foreach (list_vals[i]) if (idx < 0 && list_vals[i] == it.key) idx = i;
                    if (idx < 0) st = ST_NOTFOUND;
                    else list_vals.insert(idx, it.value);
                end
            end
            OP_REM_FRONT: begin
                if (empty) st = ST_EMPTY;
                else void'(list_vals.pop_front());
            end
            OP_REM_BACK: begin
                if (empty) st = ST_EMPTY;
                else void'(list_vals.pop_back());
            end
            OP_REM_VAL: begin
                if (empty) st = ST_EMPTY;
                else begin
                    foreach (list_vals[i]) if (idx < 0 && list_vals[i] == it.value) idx = i;
                    if (idx < 0) st = ST_NOTFOUND;
                    else list_vals.delete(idx);
                end
            end
            default: ;
        endcase
        r.status = st;
        r.occupancy = 7'(list_vals.size());
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result status=%0d occupancy=%0d",
                       o_result.status, o_result.occupancy);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_result.status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, o_result.status);
                    errors++;
                end
                if (o_result.occupancy !== exp_r.occupancy) begin
                    $error("occupancy expected %0d actual %0d",
                           exp_r.occupancy, o_result.occupancy);
                    errors++;
                end
                status_seen[exp_r.status]++;
                checked++;
            end
        end
    end

    // send one transaction; gap_ok enables random bursts and gaps
    task automatic send_item(t_op op, logic signed [31:0] val, logic signed [31:0] key,
                             bit gap_ok = 1'b1);
        t_in it;
        if (gap_ok) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left--;
        end
        it.opcode = op;
        it.value = val;
        it.key = key;
        i_item <= it;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_results.push_back(predict_list_op(it));
        op_seen[op]++;
        sent++;
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic pick_value(output logic signed [31:0] v);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6 || list_vals.size() == 0) v = $signed($urandom_range(0, 15)) - 8;
        else if (sel < 9) v = list_vals[$urandom_range(0, list_vals.size() - 1)];
        else v = $urandom();
    endtask

    task automatic test_directed();
        send_item(OP_REM_FRONT, 0, 0);
        send_item(OP_REM_BACK, 0, 0);
        send_item(OP_REM_VAL, 5, 0);
        send_item(OP_INS_KEY, 1, 2);
        send_item(OP_INS_FRONT, 32'sh7fffffff, 0);
        send_item(OP_INS_BACK, 32'sh80000000, 0);
        send_item(OP_INS_KEY, 32'shffffffff, 32'sh80000000);
        send_item(OP_INS_KEY, 3, 32'sh7fffffff);
        send_item(OP_INS_KEY, 4, 99);
        send_item(OP_NOP6, 32'sh55555555, 32'shaaaaaaaa);
        send_item(OP_NOP7, 32'shaaaaaaaa, 32'sh55555555);
        send_item(OP_REM_VAL, 32'shffffffff, 0);
        send_item(OP_REM_VAL, 77, 0);
        send_item(OP_REM_BACK, 0, 0);
        send_item(OP_REM_FRONT, 0, 0);
        send_item(OP_REM_FRONT, 0, 0);
        send_item(OP_REM_FRONT, 0, 0);
    endtask

    task automatic test_fill_and_drain();
        // fill: store full path then drain
        wait_drained();
        while (list_vals.size() < NODES)
            send_item(t_op'($urandom_range(0, 1)), $urandom(), 0);
        send_item(OP_INS_FRONT, 1, 0);
        send_item(OP_INS_BACK, 1, 0);
        send_item(OP_INS_KEY, 1, list_vals[NODES-1]);
        send_item(OP_REM_VAL, list_vals[NODES-1], 0);
        send_item(OP_INS_KEY, 9, list_vals[NODES-2]);
        while (list_vals.size() > 0)
            send_item(t_op'($urandom_range(3, 4)), 0, 0);
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic signed [31:0] v;
        logic signed [31:0] k;
        int sel;
        repeat (count) begin
            pick_value(v);
            pick_value(k);
            sel = $urandom_range(0, 99);
            if (sel < 40 && list_vals.size() < 48)
                send_item(t_op'($urandom_range(0, 2)), v, k);
            else if (sel < 80)
                send_item(t_op'($urandom_range(3, 5)), v, k);
            else if (sel < 95)
                send_item(t_op'($urandom_range(0, 5)), v, k);
            else
                send_item(t_op'($urandom_range(0, 7)), $urandom(), $urandom());
            if ($urandom_range(0, 199) == 0) wait_drained();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_and_drain();
        test_random(540);
        test_fill_and_drain();
        test_random(540);
        wait_drained();
        repeat (2 * NODES + 20) @(posedge i_clk);
        $display("sent %0d transactions, checked %0d results", sent, checked);
        $display("ops: %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d status: %0d/%0d/%0d/%0d",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
                 op_seen[6], op_seen[7], status_seen[0], status_seen[1],
                 status_seen[2], status_seen[3]);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== bounded_doubly_linked_list.f =====
rtl/bdll_pkg.sv
rtl/bdll_front.sv
rtl/bdll_queue.sv
rtl/bdll_engine.sv
rtl/bounded_doubly_linked_list.sv
test/bounded_doubly_linked_list_test.sv
